// File: rtl/core/bank_switch_mapper_with_sram_top_defines.svh
// assertion macros used by the mapper checker
`ifndef BANK_SWITCH_MAPPER_WITH_SRAM_TOP_DEFINES_SVH
`define BANK_SWITCH_MAPPER_WITH_SRAM_TOP_DEFINES_SVH

// checked only while out of reset
`define BSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define BSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/bsm_pkg.sv
// types, constants and helper functions of the bank switch mapper
package bsm_pkg;

  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned ROM_ADDR_W  = 21;
  localparam int unsigned SRAM_ADDR_W = 15;
  localparam int unsigned PAGE_BYTES  = 8192;
  localparam int unsigned PAGE_OFF_W  = $clog2(PAGE_BYTES);
  localparam int unsigned ROM_BLK_W   = ROM_ADDR_W - PAGE_OFF_W;
  localparam int unsigned SLOTS       = 4;
  localparam int unsigned SLOT_W      = $clog2(SLOTS);
  localparam int unsigned SRAM_BLK_W  = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned SIZE_W      = 2;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // page numbers (address bits 15..13)
  localparam logic [2:0] PAGE_BANK_REG = 3'd3;
  localparam logic [2:0] PAGE_SW_FIRST = 3'd2;
  localparam logic [2:0] PAGE_SW_LAST  = 3'd5;

  localparam logic [SIZE_W-1:0] SIZE_2K  = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_8K  = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_32K = 2'd2;

  localparam logic [SRAM_ADDR_W-1:0] SRAM_MASK_2K  = 15'h07FF;
  localparam logic [SRAM_ADDR_W-1:0] SRAM_MASK_8K  = 15'h1FFF;
  localparam logic [SRAM_ADDR_W-1:0] SRAM_MASK_32K = 15'h7FFF;

  localparam logic [CFG_DATA_W-1:0] SRAM_SELECT_RST    = 8'h80;
  localparam logic [CFG_DATA_W-1:0] SRAM_PAGE_MASK_RST = 8'h30;
  localparam logic [SIZE_W-1:0]     SRAM_SIZE_RST      = SIZE_8K;
  localparam logic [CFG_DATA_W-1:0] ROM_BLOCK_MASK_RST = 8'hFF;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_SRAM = 2'd2,
    TGT_BANK = 2'd3
  } target_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRAM_SELECT    = 2'd0,
    CFG_SRAM_PAGE_MASK = 2'd1,
    CFG_SRAM_SIZE      = 2'd2,
    CFG_ROM_BLOCK_MASK = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] sram_select;
    logic [CFG_DATA_W-1:0] sram_page_mask;
    logic [SIZE_W-1:0]     sram_size;
    logic [CFG_DATA_W-1:0] rom_block_mask;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    target_e                target;
    logic [ROM_ADDR_W-1:0]  rom_address;
    logic [SRAM_ADDR_W-1:0] sram_address;
    logic                   sram_write;
  } rsp_t;

  // byte mask of the sram, size code three acts as 32 kb
  function automatic logic [SRAM_ADDR_W-1:0] sram_size_mask(input logic [SIZE_W-1:0] code);
    logic [SRAM_ADDR_W-1:0] m;
    case (code)
      SIZE_2K: m = SRAM_MASK_2K;
      SIZE_8K: m = SRAM_MASK_8K;
      default: m = SRAM_MASK_32K;
    endcase
    return m;
  endfunction

  // only the 32 kb part has more than one block
  function automatic logic [SRAM_BLK_W-1:0] sram_block_mask(input logic [SIZE_W-1:0] code);
    logic [SRAM_BLK_W-1:0] m;
    if (code == SIZE_2K || code == SIZE_8K) begin
      m = '0;
    end else begin
      m = '1;
    end
    return m;
  endfunction

endpackage

// File: rtl/core/bsm_if.sv
// valid/ready channel interfaces for bus access items and mapping results
interface bsm_req_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [bsm_pkg::ADDR_W-1:0] address;
  logic [bsm_pkg::DATA_W-1:0] write_data;

  modport source (output valid, output command, output address, output write_data,
                  input ready);
  modport sink   (input valid, input command, input address, input write_data,
                  output ready);
endinterface

interface bsm_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     target;
  logic [bsm_pkg::ROM_ADDR_W-1:0]  rom_address;
  logic [bsm_pkg::SRAM_ADDR_W-1:0] sram_address;
  logic                           sram_write;

  modport source (output valid, output target, output rom_address, output sram_address,
                  output sram_write, input ready);
  modport sink   (input valid, input target, input rom_address, input sram_address,
                  input sram_write, output ready);
endinterface

// File: rtl/core/bsm_cfg_regs.sv
// configuration register file of the mapper
module bsm_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bsm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bsm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output bsm_pkg::cfg_t                      cfg_o
);

  bsm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sram_select    <= bsm_pkg::SRAM_SELECT_RST;
      cfg_q.sram_page_mask <= bsm_pkg::SRAM_PAGE_MASK_RST;
      cfg_q.sram_size      <= bsm_pkg::SRAM_SIZE_RST;
      cfg_q.rom_block_mask <= bsm_pkg::ROM_BLOCK_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (bsm_pkg::cfg_idx_e'(cfg_index_i))
        bsm_pkg::CFG_SRAM_SELECT:    cfg_q.sram_select    <= cfg_data_i;
        bsm_pkg::CFG_SRAM_PAGE_MASK: cfg_q.sram_page_mask <= cfg_data_i;
        bsm_pkg::CFG_SRAM_SIZE:      cfg_q.sram_size      <= cfg_data_i[bsm_pkg::SIZE_W-1:0];
        bsm_pkg::CFG_ROM_BLOCK_MASK: cfg_q.rom_block_mask <= cfg_data_i;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/bsm_map_core.sv
// bank registers and the address decode of one bus access
module bsm_map_core #(
  parameter int unsigned ROM_BLOCK_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bsm_pkg::cfg_t cfg_i,
  input  bsm_pkg::req_t req_i,
  input  logic          commit_i,
  output bsm_pkg::rsp_t rsp_o
);

  localparam int unsigned SlotW = bsm_pkg::SLOT_W;
  localparam int unsigned BlkW  = bsm_pkg::SRAM_BLK_W;
  localparam int unsigned OffW  = bsm_pkg::PAGE_OFF_W;

  logic                      page_is_sram_q [bsm_pkg::SLOTS];
  logic [ROM_BLOCK_BITS-1:0] rom_block_q    [bsm_pkg::SLOTS];
  logic [BlkW-1:0]           sram_block_q   [bsm_pkg::SLOTS];
  logic [bsm_pkg::SLOTS-1:0] sram_en_q;

  logic [2:0]                       page;
  logic [SlotW-1:0]                 slot;
  logic [SlotW-1:0]                 reg_slot;
  logic [2:0]                       reg_page;
  logic                             in_window;
  logic                             bank_wr;
  logic                             sel_sram;
  logic [OffW-1:0]                  offset;
  logic [bsm_pkg::SRAM_ADDR_W-1:0]  size_mask;
  logic [bsm_pkg::SRAM_ADDR_W-1:0]  sram_addr;
  logic [bsm_pkg::ROM_BLK_W-1:0]    rom_blk_ext;
  logic [ROM_BLOCK_BITS-1:0]        rom_blk_new;
  logic [BlkW-1:0]                  sram_blk_new;

  assign page      = req_i.address[bsm_pkg::ADDR_W-1:OffW];
  assign slot      = SlotW'(page - bsm_pkg::PAGE_SW_FIRST);
  assign in_window = (page >= bsm_pkg::PAGE_SW_FIRST) && (page <= bsm_pkg::PAGE_SW_LAST);
  assign offset    = req_i.address[OffW-1:0];
  assign bank_wr   = (req_i.command == bsm_pkg::CMD_WRITE) && (page == bsm_pkg::PAGE_BANK_REG);
  // address bits 12..11 pick the page that a bank write switches
  assign reg_slot  = req_i.address[OffW-1:OffW-SlotW];
  assign reg_page  = 3'({1'b0, reg_slot}) + bsm_pkg::PAGE_SW_FIRST;
  assign sel_sram  = |(req_i.write_data & cfg_i.sram_select);

  assign sram_blk_new = req_i.write_data[BlkW-1:0] & bsm_pkg::sram_block_mask(cfg_i.sram_size);
  assign rom_blk_new  = req_i.write_data[ROM_BLOCK_BITS-1:0]
                      & cfg_i.rom_block_mask[ROM_BLOCK_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bsm_pkg::SLOTS; i++) begin
        page_is_sram_q[i] <= 1'b0;
        rom_block_q[i]    <= '0;
        sram_block_q[i]   <= '0;
      end
      sram_en_q <= '0;
    end else if (commit_i && bank_wr) begin
      page_is_sram_q[reg_slot] <= sel_sram;
      if (sel_sram) begin
        sram_block_q[reg_slot] <= sram_blk_new;
        if (cfg_i.sram_page_mask[reg_page]) begin
          sram_en_q[reg_slot] <= 1'b1;
        end
      end else begin
        rom_block_q[reg_slot] <= rom_blk_new;
        sram_en_q[reg_slot]   <= 1'b0;
      end
    end
  end

  // sram byte address: block above the page offset, mirrored to the part size
  assign size_mask   = bsm_pkg::sram_size_mask(cfg_i.sram_size);
  assign sram_addr   = {sram_block_q[slot], offset & size_mask[OffW-1:0]} & size_mask;
  assign rom_blk_ext = bsm_pkg::ROM_BLK_W'(rom_block_q[slot]);

  always_comb begin
    rsp_o.target       = bsm_pkg::TGT_NONE;
    rsp_o.rom_address  = '0;
    rsp_o.sram_address = '0;
    rsp_o.sram_write   = 1'b0;
    if (bank_wr) begin
      rsp_o.target = bsm_pkg::TGT_BANK;
    end else if (req_i.command == bsm_pkg::CMD_WRITE) begin
      if (in_window && sram_en_q[slot]) begin
        rsp_o.target       = bsm_pkg::TGT_SRAM;
        rsp_o.sram_address = sram_addr;
        rsp_o.sram_write   = 1'b1;
      end
    end else if (in_window) begin
      if (page_is_sram_q[slot] || sram_en_q[slot]) begin
        rsp_o.target       = bsm_pkg::TGT_SRAM;
        rsp_o.sram_address = sram_addr;
      end else begin
        rsp_o.target      = bsm_pkg::TGT_ROM;
        rsp_o.rom_address = {rom_blk_ext, offset};
      end
    end
  end

endmodule

// File: rtl/core/bank_switch_mapper_with_sram_top.sv
// bank switch cartridge mapper with sram: input register, decode, result register
// an accepted item is decoded in the input register and moves to the result register when free
// throughput: one item per cycle unless stalled, set by one decode stage and the bank update
// a result waiting on the output does not block intake while the input register is free
// reset: all pages map rom block zero, no sram enabled, config registers take their defaults
// results are in flight only while valid; both stages empty after reset
module bank_switch_mapper_with_sram_top #(
  parameter int unsigned ROM_BLOCK_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bsm_req_if.sink                        req_i,
  bsm_rsp_if.source                      rsp_o,
  input  logic                           cfg_we_i,
  input  logic [bsm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  bsm_pkg::cfg_t cfg;
  bsm_pkg::req_t s1_q, s1_d;
  bsm_pkg::rsp_t map_rsp;
  bsm_pkg::rsp_t out_q;
  logic          s1_valid_q, s1_valid_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free;
  logic          s1_move;
  logic          accept;

  bsm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bsm_map_core #(
    .ROM_BLOCK_BITS (ROM_BLOCK_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .req_i    (s1_q),
    .commit_i (s1_move),
    .rsp_o    (map_rsp)
  );

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign s1_move     = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || out_free;
  assign accept      = req_i.valid && req_i.ready;

  assign s1_d.command    = req_i.command;
  assign s1_d.address    = req_i.address;
  assign s1_d.write_data = req_i.write_data;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_move) begin
      out_q <= map_rsp;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.target       = out_q.target;
  assign rsp_o.rom_address  = out_q.rom_address;
  assign rsp_o.sram_address = out_q.sram_address;
  assign rsp_o.sram_write   = out_q.sram_write;

endmodule

// File: rtl/core/bsm_checker.sv
// port level checks of the mapper result channel, bound to the top level
`include "bank_switch_mapper_with_sram_top_defines.svh"

module bsm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input logic [1:0]                      rsp_target_i,
  input logic [bsm_pkg::ROM_ADDR_W-1:0]  rsp_rom_address_i,
  input logic [bsm_pkg::SRAM_ADDR_W-1:0] rsp_sram_address_i,
  input logic                            rsp_sram_write_i
);

  // no item comes out in the cycle after reset
  `BSM_ASSERT_ALWAYS(a_idle_after_reset, !rst_ni |=> !rsp_valid_i, "result valid right after reset")

  // a stalled item holds
  `BSM_ASSERT(a_stall_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_target_i) && $stable(rsp_rom_address_i) && $stable(rsp_sram_address_i) && $stable(rsp_sram_write_i), "stalled result changed")

  `BSM_ASSERT(a_store_is_sram, rsp_valid_i && rsp_sram_write_i |-> rsp_target_i == bsm_pkg::TGT_SRAM, "sram store without sram target")

  `BSM_ASSERT(a_rom_addr_zero, rsp_valid_i && rsp_target_i != bsm_pkg::TGT_ROM |-> rsp_rom_address_i == '0, "rom address set off rom target")

  `BSM_ASSERT(a_sram_addr_zero, rsp_valid_i && rsp_target_i != bsm_pkg::TGT_SRAM |-> rsp_sram_address_i == '0, "sram address set off sram target")

endmodule

bind bank_switch_mapper_with_sram_top bsm_checker u_bsm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_target_i       (rsp_o.target),
  .rsp_rom_address_i  (rsp_o.rom_address),
  .rsp_sram_address_i (rsp_o.sram_address),
  .rsp_sram_write_i   (rsp_o.sram_write)
);

// File: test/bank_switch_mapper_with_sram_top_tb.sv
// testbench of the bank switch mapper: directed and random bus accesses checked against a predictor
module bank_switch_mapper_with_sram_top_tb;

  localparam int CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [bsm_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [bsm_pkg::CFG_DATA_W-1:0] cfg_data_i;

  bsm_req_if req_ch ();
  bsm_rsp_if rsp_ch ();

  bank_switch_mapper_with_sram_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the configuration and the bank state
  logic [7:0] sel_mask;
  logic [7:0] page_mask;
  logic [1:0] size_code;
  logic [7:0] rom_mask;
  logic       slot_sram [bsm_pkg::SLOTS];
  logic [7:0] slot_rom  [bsm_pkg::SLOTS];
  logic [1:0] slot_sblk [bsm_pkg::SLOTS];
  logic [7:0] sram_on;

  bsm_pkg::rsp_t expected_maps[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  bit   idle_on = 1'b1;
  bit   stall_on = 1'b1;

  function automatic logic [14:0] sram_span();
    case (size_code)
      bsm_pkg::SIZE_2K: return bsm_pkg::SRAM_MASK_2K;
      bsm_pkg::SIZE_8K: return bsm_pkg::SRAM_MASK_8K;
      default: return bsm_pkg::SRAM_MASK_32K;
    endcase
  endfunction

  function automatic logic [14:0] sram_xlate(input int slot, input logic [15:0] addr);
    logic [31:0] span;
    logic [31:0] a;
    span = {17'd0, sram_span()};
    a = slot_sblk[slot] * 32'h2000 + ({16'd0, addr} & span & 32'h1FFF);
    a = a & span;
    return a[14:0];
  endfunction

  // works out the result of one access and updates the bank state
  function automatic bsm_pkg::rsp_t map_access(input logic cmd, input logic [15:0] addr,
                                               input logic [7:0] data);
    bsm_pkg::rsp_t r;
    int   page;
    int   slot;
    int   region;
    logic [7:0] bit_of;
    r.target = bsm_pkg::TGT_NONE;
    r.rom_address = '0;
    r.sram_address = '0;
    r.sram_write = 1'b0;
    page = addr[15:13];
    if (cmd == bsm_pkg::CMD_WRITE && addr >= 16'h6000 && addr < 16'h8000) begin
      slot = addr[12:11];
      region = slot + 2;
      bit_of = 8'(1 << region);
      if ((data & sel_mask) != 8'd0) begin
        slot_sram[slot] = 1'b1;
        slot_sblk[slot] = (size_code == bsm_pkg::SIZE_2K || size_code == bsm_pkg::SIZE_8K) ?
                          2'd0 : data[1:0];
        sram_on = sram_on | (bit_of & page_mask);
      end else begin
        slot_sram[slot] = 1'b0;
        slot_rom[slot] = data & rom_mask;
        sram_on = sram_on & ~bit_of;
      end
      r.target = bsm_pkg::TGT_BANK;
    end else if (page >= bsm_pkg::PAGE_SW_FIRST && page <= bsm_pkg::PAGE_SW_LAST) begin
      slot = page - 2;
      if (cmd == bsm_pkg::CMD_WRITE) begin
        if (sram_on[page]) begin
          r.target = bsm_pkg::TGT_SRAM;
          r.sram_address = sram_xlate(slot, addr);
          r.sram_write = 1'b1;
        end
      end else if (slot_sram[slot] || sram_on[page]) begin
        r.target = bsm_pkg::TGT_SRAM;
        r.sram_address = sram_xlate(slot, addr);
      end else begin
        r.target = bsm_pkg::TGT_ROM;
        r.rom_address = {slot_rom[slot], addr[12:0]};
      end
    end
    return r;
  endfunction

  // one access item, with an optional gap before it
  task automatic send_access(input logic cmd, input logic [15:0] addr, input logic [7:0] data);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= cmd;
    req_ch.address <= addr;
    req_ch.write_data <= data;
    do @(posedge clk_i); while (!req_ch.ready);
    expected_maps.push_back(map_access(cmd, addr, data));
  endtask

  task automatic send_random_access();
    int pick;
    logic [15:0] addr;
    pick = $urandom_range(0, 9);
    if (pick <= 2) begin
      addr = 16'h6000 | 16'($urandom_range(0, 16'h1FFF));
      send_access(bsm_pkg::CMD_WRITE, addr, 8'($urandom));
    end else if (pick <= 5) begin
      send_access(bsm_pkg::CMD_READ, 16'($urandom_range(16'h4000, 16'hBFFF)), 8'($urandom));
    end else if (pick <= 7) begin
      send_access(bsm_pkg::CMD_WRITE, 16'($urandom_range(16'h4000, 16'hBFFF)), 8'($urandom));
    end else begin
      send_access(1'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (expected_maps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [7:0] sel, input logic [7:0] pmask,
                              input logic [1:0] size, input logic [7:0] rmask);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= bsm_pkg::CFG_SRAM_SELECT;
    cfg_data_i <= sel;
    @(posedge clk_i);
    cfg_index_i <= bsm_pkg::CFG_SRAM_PAGE_MASK;
    cfg_data_i <= pmask;
    @(posedge clk_i);
    cfg_index_i <= bsm_pkg::CFG_SRAM_SIZE;
    cfg_data_i <= {6'd0, size};
    @(posedge clk_i);
    cfg_index_i <= bsm_pkg::CFG_ROM_BLOCK_MASK;
    cfg_data_i <= rmask;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sel_mask = sel;
    page_mask = pmask;
    size_code = size;
    rom_mask = rmask;
  endtask

  task automatic test_reset_map();
    send_access(bsm_pkg::CMD_READ, 16'h0000, 8'h00);
    send_access(bsm_pkg::CMD_READ, 16'hFFFF, 8'hFF);
    send_access(bsm_pkg::CMD_READ, 16'h4000, 8'h00);
    send_access(bsm_pkg::CMD_READ, 16'hBFFF, 8'h00);
    send_access(bsm_pkg::CMD_READ, 16'h7FFF, 8'h00);
    // writes to rom pages go nowhere
    send_access(bsm_pkg::CMD_WRITE, 16'h4000, 8'hFF);
    send_access(bsm_pkg::CMD_WRITE, 16'hC000, 8'h00);
  endtask

  task automatic test_bank_switching();
    send_access(bsm_pkg::CMD_WRITE, 16'h6000, 8'h7F);
    send_access(bsm_pkg::CMD_WRITE, 16'h7FFF, 8'hFF);
    send_access(bsm_pkg::CMD_WRITE, 16'h7000, 8'h00);
    // page 3 gets sram but is outside the page mask
    send_access(bsm_pkg::CMD_WRITE, 16'h6800, 8'h80);
    send_access(bsm_pkg::CMD_READ, 16'h5FFF, 8'h00);
    send_access(bsm_pkg::CMD_READ, 16'hA000, 8'h00);
    send_access(bsm_pkg::CMD_WRITE, 16'hBFFF, 8'h00);
    send_access(bsm_pkg::CMD_READ, 16'h7800, 8'h00);
    send_access(bsm_pkg::CMD_WRITE, 16'h9000, 8'h12);
    send_access(bsm_pkg::CMD_WRITE, 16'h6000, 8'h81);
    send_access(bsm_pkg::CMD_WRITE, 16'h4ABC, 8'h55);
    send_access(bsm_pkg::CMD_READ, 16'h4ABC, 8'h00);
    send_access(bsm_pkg::CMD_WRITE, 16'h7000, 8'hC0);
    send_access(bsm_pkg::CMD_WRITE, 16'h8001, 8'hAA);
    // back to rom drops the write enable of page 5
    send_access(bsm_pkg::CMD_WRITE, 16'h7800, 8'h05);
    send_access(bsm_pkg::CMD_READ, 16'hA555, 8'h00);
  endtask

  task automatic test_config_sweep();
    logic [7:0] sels  [5] = '{8'h80, 8'hFF, 8'h00, 8'h01, 8'h80};
    logic [7:0] pmsks [5] = '{8'h30, 8'hFF, 8'h00, 8'h3C, 8'h30};
    logic [1:0] sizes [5] = '{bsm_pkg::SIZE_32K, bsm_pkg::SIZE_2K, 2'd3, bsm_pkg::SIZE_32K,
                              bsm_pkg::SIZE_8K};
    logic [7:0] rmsks [5] = '{8'h0F, 8'h00, 8'hFF, 8'h01, 8'hFF};
    for (int k = 0; k < 5; k++) begin
      apply_config(sels[k], pmsks[k], sizes[k], rmsks[k]);
      // one setting runs without gaps on either side
      idle_on = (k != 2);
      stall_on = (k != 2);
      repeat (60) send_random_access();
    end
    idle_on = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    apply_config(8'($urandom), 8'($urandom), 2'($urandom_range(0, 3)), 8'($urandom));
    repeat (50) send_random_access();
    drain();
    repeat (50) send_random_access();
  endtask

  task automatic test_no_idle_tail();
    idle_on = 1'b0;
    stall_on = 1'b0;
    repeat (60) send_random_access();
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_on && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(posedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    bsm_pkg::rsp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_maps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: target %0d rom %h sram %h wr %b", rsp_ch.target,
                   rsp_ch.rom_address, rsp_ch.sram_address, rsp_ch.sram_write);
        end
      end else begin
        want = expected_maps.pop_front();
        if (rsp_ch.target !== want.target || rsp_ch.rom_address !== want.rom_address ||
            rsp_ch.sram_address !== want.sram_address ||
            rsp_ch.sram_write !== want.sram_write) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: exp target %0d rom %h sram %h wr %b, got %0d %h %h %b",
                     want.target, want.rom_address, want.sram_address, want.sram_write,
                     rsp_ch.target, rsp_ch.rom_address, rsp_ch.sram_address,
                     rsp_ch.sram_write);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = bsm_pkg::CFG_SRAM_SELECT;
    cfg_data_i = '0;
    req_ch.valid = 1'b0;
    req_ch.command = bsm_pkg::CMD_READ;
    req_ch.address = '0;
    req_ch.write_data = '0;
    sel_mask = bsm_pkg::SRAM_SELECT_RST;
    page_mask = bsm_pkg::SRAM_PAGE_MASK_RST;
    size_code = bsm_pkg::SRAM_SIZE_RST;
    rom_mask = bsm_pkg::ROM_BLOCK_MASK_RST;
    sram_on = '0;
    for (int s = 0; s < bsm_pkg::SLOTS; s++) begin
      slot_sram[s] = 1'b0;
      slot_rom[s] = '0;
      slot_sblk[s] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_map();
    test_bank_switching();
    test_config_sweep();
    test_random_traffic();
    test_no_idle_tail();

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_maps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
